@@ rtl/blps_pkg.sv @@
package blps_pkg;

  // Width of every channel countdown timer.
  localparam int TIMER_BITS = 8;

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [2:0]            mode_t;
  typedef logic [7:0]            ticks_t;
  typedef logic [1:0]            chan_t;

  // Channel modes; codes five to seven behave as off.
  localparam mode_t MODE_OFF     = 3'd0;
  localparam mode_t MODE_ON      = 3'd1;
  localparam mode_t MODE_SHORT   = 3'd2;
  localparam mode_t MODE_LONG    = 3'd3;
  localparam mode_t MODE_MEANDER = 3'd4;

  // Input operations.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  // Channel numbers.
  localparam chan_t CH_BUZZER = 2'd0;
  localparam chan_t CH_RED    = 2'd1;
  localparam chan_t CH_GREEN  = 2'd2;
  localparam chan_t CH_WHITE  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SHORT_TICKS   = 2'd0;
  localparam logic [1:0] CFG_LONG_TICKS    = 2'd1;
  localparam logic [1:0] CFG_MEANDER_TICKS = 2'd2;
  localparam logic [1:0] CFG_SOUND_ENABLE  = 2'd3;

  // A loaded tick count keeps only the bits the timer can hold.
  function automatic timer_t load_ticks(input ticks_t ticks);
    return timer_t'(ticks);
  endfunction

endpackage

@@ rtl/buzzer_lamp_pattern_sequencer.sv @@
// Buzzer and lamp pattern sequencer. Each beat on the input channel is either
// a tick, which advances the buzzer and the red, green and white lamps by one
// step of their patterns, or a set-mode command for one channel. Every input
// beat produces exactly one output beat carrying the four pin levels after
// that beat. The block takes one input beat per clock cycle unless stalled:
// the whole update is a few timer decrements and compares done in the cycle
// the beat is accepted, and the new pin levels are presented from registers
// in the next cycle. The output register is the only thing that can hold the
// input back: while a result waits for out_ready, in_ready stays low, and it
// is high in the same cycle the waiting result is taken. Configuration writes
// are taken in every cycle (cfg_ready is always high) and should only be
// issued while no beat is in flight. Lamp pins always follow the lamp status;
// the buzzer pin copies the buzzer status only on beats that touch the buzzer
// while sound_enable is set, and otherwise holds its level.
module buzzer_lamp_pattern_sequencer (
  input  logic       clk,
  input  logic       rst,
  // Configuration write channel.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // Input channel.
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       operation,
  input  logic [1:0] channel,
  input  logic [2:0] mode_code,
  // Output channel.
  output logic       out_valid,
  input  logic       out_ready,
  output logic       buzzer_out,
  output logic       red_out,
  output logic       green_out,
  output logic       white_out
);

  // Configuration registers.
  blps_pkg::ticks_t short_ticks;
  blps_pkg::ticks_t long_ticks;
  blps_pkg::ticks_t meander_ticks;
  logic             sound_enable;

  // Per-channel state; index 0 is the buzzer, 1 to 3 are the lamps.
  blps_pkg::mode_t  mode   [4];
  blps_pkg::timer_t timer  [4];
  logic [3:0]       status;
  logic             buzzer_pin;

  blps_pkg::mode_t  mode_next   [4];
  blps_pkg::timer_t timer_next  [4];
  logic [3:0]       status_next;
  logic             buzzer_pin_next;

  blps_pkg::timer_t timer_dec [4];
  blps_pkg::timer_t ld_short;
  blps_pkg::timer_t ld_long;
  blps_pkg::timer_t ld_meander;

  logic in_accept;

  // The output register is freed when its beat is taken, so a new input
  // beat can enter in the same cycle.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign ld_short   = blps_pkg::load_ticks(short_ticks);
  assign ld_long    = blps_pkg::load_ticks(long_ticks);
  assign ld_meander = blps_pkg::load_ticks(meander_ticks);

  for (genvar g = 0; g < 4; g++) begin : g_dec
    assign timer_dec[g] = timer[g] - blps_pkg::timer_t'(1);
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mode_next[i]  = mode[i];
      timer_next[i] = timer[i];
    end
    status_next     = status;
    buzzer_pin_next = buzzer_pin;

    if (in_accept) begin
      if (operation == blps_pkg::OP_TICK) begin
        // Buzzer: short and long give one beep, then fall to off. A zero
        // timer in those modes keeps the mode but stays silent.
        case (mode[0])
          blps_pkg::MODE_SHORT, blps_pkg::MODE_LONG: begin
            status_next[0] = 1'b0;
            if (timer[0] != '0) begin
              timer_next[0] = timer_dec[0];
              if (timer_dec[0] != '0) begin
                status_next[0] = 1'b1;
              end else begin
                mode_next[0] = blps_pkg::MODE_OFF;
              end
            end
          end
          blps_pkg::MODE_MEANDER: begin
            if (timer[0] != '0) begin
              timer_next[0] = timer_dec[0];
              if (timer_dec[0] == '0) begin
                status_next[0] = !status[0];
                timer_next[0]  = ld_meander;
              end
            end
          end
          default: begin
            // Steady on and the unused codes act as off for the buzzer.
            status_next[0] = 1'b0;
            mode_next[0]   = blps_pkg::MODE_OFF;
          end
        endcase

        // Lamps repeat their pattern; a zero timer freezes the status.
        for (int i = 1; i < 4; i++) begin
          case (mode[i])
            blps_pkg::MODE_SHORT, blps_pkg::MODE_LONG, blps_pkg::MODE_MEANDER: begin
              if (timer[i] != '0) begin
                timer_next[i] = timer_dec[i];
                if (timer_dec[i] == '0) begin
                  if (mode[i] == blps_pkg::MODE_MEANDER) begin
                    status_next[i] = !status[i];
                    timer_next[i]  = ld_meander;
                  end else if (status[i]) begin
                    status_next[i] = 1'b0;
                    timer_next[i]  = (mode[i] == blps_pkg::MODE_SHORT) ? ld_long : ld_short;
                  end else begin
                    status_next[i] = 1'b1;
                    timer_next[i]  = (mode[i] == blps_pkg::MODE_SHORT) ? ld_short : ld_long;
                  end
                end
              end
            end
            blps_pkg::MODE_ON: begin
              status_next[i] = 1'b1;
            end
            default: begin
              status_next[i] = 1'b0;
              mode_next[i]   = blps_pkg::MODE_OFF;
            end
          endcase
        end

        if (sound_enable) begin
          buzzer_pin_next = status_next[0];
        end
      end else if (channel == blps_pkg::CH_BUZZER) begin
        mode_next[0] = mode_code;
        case (mode_code)
          blps_pkg::MODE_SHORT: begin
            timer_next[0]  = ld_short;
            status_next[0] = 1'b1;
          end
          blps_pkg::MODE_LONG: begin
            timer_next[0]  = ld_long;
            status_next[0] = 1'b1;
          end
          blps_pkg::MODE_MEANDER: begin
            timer_next[0]  = ld_meander;
            status_next[0] = 1'b1;
          end
          default: begin
            timer_next[0]  = '0;
            status_next[0] = 1'b0;
          end
        endcase
        if (sound_enable) begin
          buzzer_pin_next = status_next[0];
        end
      end else begin
        // Lamp set; steady on and off leave the timer as it is.
        for (int i = 1; i < 4; i++) begin
          if (channel == 2'(i)) begin
            mode_next[i] = mode_code;
            case (mode_code)
              blps_pkg::MODE_SHORT: begin
                timer_next[i]  = ld_short;
                status_next[i] = 1'b1;
              end
              blps_pkg::MODE_LONG: begin
                timer_next[i]  = ld_long;
                status_next[i] = 1'b1;
              end
              blps_pkg::MODE_MEANDER: begin
                timer_next[i]  = ld_meander;
                status_next[i] = 1'b1;
              end
              blps_pkg::MODE_ON: begin
                status_next[i] = 1'b1;
              end
              default: begin
                status_next[i] = 1'b0;
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_ticks   <= 8'd10;
      long_ticks    <= 8'd50;
      meander_ticks <= 8'd25;
      sound_enable  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        blps_pkg::CFG_SHORT_TICKS:   short_ticks   <= cfg_data;
        blps_pkg::CFG_LONG_TICKS:    long_ticks    <= cfg_data;
        blps_pkg::CFG_MEANDER_TICKS: meander_ticks <= cfg_data;
        blps_pkg::CFG_SOUND_ENABLE:  sound_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        mode[i]  <= blps_pkg::MODE_OFF;
        timer[i] <= '0;
      end
      status     <= '0;
      buzzer_pin <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      for (int i = 0; i < 4; i++) begin
        mode[i]  <= mode_next[i];
        timer[i] <= timer_next[i];
      end
      status     <= status_next;
      buzzer_pin <= buzzer_pin_next;
      if (in_accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // State only moves on an accepted beat, and no beat is accepted while a
  // result is stalled, so the state registers double as the result register.
  assign buzzer_out = buzzer_pin;
  assign red_out    = status[blps_pkg::CH_RED];
  assign green_out  = status[blps_pkg::CH_GREEN];
  assign white_out  = status[blps_pkg::CH_WHITE];

endmodule

@@ verif/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import blps_pkg::*;

  // Spare mode codes. The block treats all three as off.
  localparam mode_t MODE_SPARE5 = 3'd5;
  localparam mode_t MODE_SPARE6 = 3'd6;
  localparam mode_t MODE_SPARE7 = 3'd7;

  localparam int RANDOM_BEATS = 2000;

  // One result beat: the four pin levels after an input beat.
  typedef struct packed {
    logic buzzer;
    logic red;
    logic green;
    logic white;
  } pins_t;

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic       operation;
  logic [1:0] channel;
  logic [2:0] mode_code;
  logic       out_valid;
  logic       out_ready;
  logic       buzzer_out;
  logic       red_out;
  logic       green_out;
  logic       white_out;

  buzzer_lamp_pattern_sequencer dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .channel    (channel),
    .mode_code  (mode_code),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .buzzer_out (buzzer_out),
    .red_out    (red_out),
    .green_out  (green_out),
    .white_out  (white_out)
  );

  // 20 ns clock period.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Pattern predictor. It keeps its own copy of the mode, timer and status of
  // every channel, the frozen buzzer pin and the four registers, and it is
  // advanced once for every input beat the block accepts.
  // ---------------------------------------------------------------------------
  mode_t  chan_mode   [4];
  timer_t chan_timer  [4];
  logic   chan_status [4];
  logic   buzz_pin;
  ticks_t cfg_short;
  ticks_t cfg_long;
  ticks_t cfg_meander;
  logic   cfg_sound;

  // Pin levels the block should present, oldest first.
  pins_t expected_pins [$];
  int    mismatch_count;

  function automatic void reset_patterns();
    cfg_short   = 8'd10;
    cfg_long    = 8'd50;
    cfg_meander = 8'd25;
    cfg_sound   = 1'b1;
    for (int i = 0; i < 4; i++) begin
      chan_mode[i]   = MODE_OFF;
      chan_timer[i]  = '0;
      chan_status[i] = 1'b0;
    end
    buzz_pin = 1'b0;
  endfunction

  function automatic void apply_register(logic [1:0] idx, logic [7:0] data);
    case (idx)
      CFG_SHORT_TICKS:   cfg_short   = data;
      CFG_LONG_TICKS:    cfg_long    = data;
      CFG_MEANDER_TICKS: cfg_meander = data;
      CFG_SOUND_ENABLE:  cfg_sound   = data[0];
      default: ;
    endcase
  endfunction

  // A lamp in a timed mode starts in its on phase with a fresh timer. Steady
  // modes leave the timer alone; anything else switches the lamp off.
  function automatic void set_lamp(chan_t ch, mode_t m);
    chan_mode[ch] = m;
    case (m)
      MODE_SHORT: begin
        chan_timer[ch]  = timer_t'(cfg_short);
        chan_status[ch] = 1'b1;
      end
      MODE_LONG: begin
        chan_timer[ch]  = timer_t'(cfg_long);
        chan_status[ch] = 1'b1;
      end
      MODE_MEANDER: begin
        chan_timer[ch]  = timer_t'(cfg_meander);
        chan_status[ch] = 1'b1;
      end
      MODE_ON: chan_status[ch] = 1'b1;
      default: chan_status[ch] = 1'b0;
    endcase
  endfunction

  // Unlike a lamp, the buzzer clears its timer for every untimed mode.
  function automatic void set_buzzer(mode_t m);
    chan_mode[CH_BUZZER] = m;
    case (m)
      MODE_SHORT: begin
        chan_timer[CH_BUZZER]  = timer_t'(cfg_short);
        chan_status[CH_BUZZER] = 1'b1;
      end
      MODE_LONG: begin
        chan_timer[CH_BUZZER]  = timer_t'(cfg_long);
        chan_status[CH_BUZZER] = 1'b1;
      end
      MODE_MEANDER: begin
        chan_timer[CH_BUZZER]  = timer_t'(cfg_meander);
        chan_status[CH_BUZZER] = 1'b1;
      end
      default: begin
        chan_timer[CH_BUZZER]  = '0;
        chan_status[CH_BUZZER] = 1'b0;
      end
    endcase
  endfunction

  // When a lamp timer runs out, short and long swap phases and reload the
  // length of the new phase, while meander toggles and reloads its half
  // period. A timer already at zero freezes the lamp.
  function automatic void step_lamp(chan_t ch);
    mode_t  m;
    timer_t t;
    m = chan_mode[ch];
    t = chan_timer[ch];
    if (m == MODE_SHORT || m == MODE_LONG || m == MODE_MEANDER) begin
      if (t != '0) begin
        t = t - 1'b1;
        if (t == '0) begin
          if (m == MODE_MEANDER) begin
            chan_status[ch] = ~chan_status[ch];
            t = timer_t'(cfg_meander);
          end else if (chan_status[ch]) begin
            chan_status[ch] = 1'b0;
            t = timer_t'((m == MODE_SHORT) ? cfg_long : cfg_short);
          end else begin
            chan_status[ch] = 1'b1;
            t = timer_t'((m == MODE_SHORT) ? cfg_short : cfg_long);
          end
        end
        chan_timer[ch] = t;
      end
    end else if (m == MODE_ON) begin
      chan_status[ch] = 1'b1;
    end else begin
      chan_status[ch] = 1'b0;
      chan_mode[ch]   = MODE_OFF;
    end
  endfunction

  // Short and long give a single beep and then fall back to off. A beep with
  // a zero timer keeps its mode but never sounds.
  function automatic void step_buzzer();
    mode_t  m;
    timer_t t;
    m = chan_mode[CH_BUZZER];
    t = chan_timer[CH_BUZZER];
    if (m == MODE_SHORT || m == MODE_LONG) begin
      chan_status[CH_BUZZER] = 1'b0;
      if (t != '0) begin
        t = t - 1'b1;
        chan_timer[CH_BUZZER] = t;
        if (t != '0) chan_status[CH_BUZZER] = 1'b1;
        else chan_mode[CH_BUZZER] = MODE_OFF;
      end
    end else if (m == MODE_MEANDER) begin
      if (t != '0) begin
        t = t - 1'b1;
        if (t == '0) begin
          chan_status[CH_BUZZER] = ~chan_status[CH_BUZZER];
          t = timer_t'(cfg_meander);
        end
        chan_timer[CH_BUZZER] = t;
      end
    end else begin
      chan_status[CH_BUZZER] = 1'b0;
      chan_mode[CH_BUZZER]   = MODE_OFF;
    end
  endfunction

  // Advances the predictor by one input beat and returns the pins after it.
  // The buzzer pin only moves on beats that touch the buzzer with sound on.
  function automatic pins_t predict_pins(logic op, chan_t ch, mode_t m);
    logic buzz_touched;
    buzz_touched = 1'b0;
    if (op == OP_TICK) begin
      step_buzzer();
      step_lamp(CH_RED);
      step_lamp(CH_GREEN);
      step_lamp(CH_WHITE);
      buzz_touched = 1'b1;
    end else if (ch == CH_BUZZER) begin
      set_buzzer(m);
      buzz_touched = 1'b1;
    end else begin
      set_lamp(ch, m);
    end
    if (buzz_touched && cfg_sound) buzz_pin = chan_status[CH_BUZZER];
    return '{buzz_pin, chan_status[CH_RED], chan_status[CH_GREEN],
             chan_status[CH_WHITE]};
  endfunction

  // ---------------------------------------------------------------------------
  // Idle control. Each side draws a random idle wait for every beat, except
  // during stretches where its no-idle flag is set.
  // ---------------------------------------------------------------------------
  bit tx_no_idle;
  bit rx_no_idle;
  int rx_stall;

  function automatic int draw_wait(bit no_idle);
    if (no_idle) return 0;
    return $urandom_range(0, 11);
  endfunction

  // The receiver holds out_ready low for the drawn number of cycles after
  // each result beat. Inputs only change on the falling edge.
  always @(negedge clk) begin
    out_ready = (rx_stall == 0);
    if (rx_stall != 0) rx_stall--;
  end

  // ---------------------------------------------------------------------------
  // Result checker. Every output beat is compared with the oldest predicted
  // pin set, field by field. It samples on the rising edge, when the inputs
  // have been stable for half a period.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    pins_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_pins.size() == 0) begin
        $error("result beat with no prediction pending: buzzer %0b red %0b green %0b white %0b",
               buzzer_out, red_out, green_out, white_out);
        mismatch_count++;
      end else begin
        want = expected_pins.pop_front();
        if (buzzer_out !== want.buzzer) begin
          $error("buzzer_out: expected %0b, actual %0b", want.buzzer, buzzer_out);
          mismatch_count++;
        end
        if (red_out !== want.red) begin
          $error("red_out: expected %0b, actual %0b", want.red, red_out);
          mismatch_count++;
        end
        if (green_out !== want.green) begin
          $error("green_out: expected %0b, actual %0b", want.green, green_out);
          mismatch_count++;
        end
        if (white_out !== want.white) begin
          $error("white_out: expected %0b, actual %0b", want.white, white_out);
          mismatch_count++;
        end
      end
      rx_stall = draw_wait(rx_no_idle);
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers. Every task starts and ends on a falling edge.
  // ---------------------------------------------------------------------------

  // Sends one input beat. When the drawn gap is zero, valid stays high from
  // the previous beat and only the payload changes, so there is no bubble.
  // The prediction is queued at the edge where the beat is taken.
  task automatic send_beat(logic op, chan_t ch, mode_t m);
    int gap;
    gap = draw_wait(tx_no_idle);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation = op;
    channel   = ch;
    mode_code = m;
    in_valid  = 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    expected_pins.push_back(predict_pins(op, ch, m));
    @(negedge clk);
  endtask

  // Stops the sender and waits until every predicted beat has come back.
  task automatic drain_results();
    in_valid = 1'b0;
    while (expected_pins.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [7:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    apply_register(idx, data);
    @(negedge clk);
  endtask

  // Writes all four registers back to back; only called while idle.
  task automatic write_registers(ticks_t sh, ticks_t lg, ticks_t md, logic [7:0] snd);
    write_register(CFG_SHORT_TICKS, sh);
    write_register(CFG_LONG_TICKS, lg);
    write_register(CFG_MEANDER_TICKS, md);
    write_register(CFG_SOUND_ENABLE, snd);
    cfg_valid = 1'b0;
  endtask

  task automatic send_tick();
    send_beat(OP_TICK, chan_t'($urandom_range(0, 3)), mode_t'($urandom_range(0, 7)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Every mode on at least one channel with very short phases, so lamp patterns
  // wrap and the buzzer finishes its beep within a few ticks. Ticks carry
  // junk in the channel and mode fields, which the block must ignore.
  task automatic test_mode_patterns();
    write_registers(8'd1, 8'd2, 8'd1, 8'd1);
    send_beat(OP_SET, CH_RED, MODE_SHORT);
    send_beat(OP_SET, CH_GREEN, MODE_LONG);
    send_beat(OP_SET, CH_WHITE, MODE_MEANDER);
    send_beat(OP_SET, CH_BUZZER, MODE_SHORT);
    send_beat(OP_TICK, CH_WHITE, MODE_SPARE7);
    send_beat(OP_TICK, CH_GREEN, MODE_MEANDER);
    send_beat(OP_TICK, CH_RED, MODE_ON);
    send_beat(OP_SET, CH_BUZZER, MODE_MEANDER);
    send_beat(OP_TICK, CH_BUZZER, MODE_OFF);
    // Steady on means off for the buzzer, but holds a lamp on.
    send_beat(OP_SET, CH_BUZZER, MODE_ON);
    send_beat(OP_SET, CH_RED, MODE_ON);
    // Spare codes are stored as given and cleared to off by the next tick.
    send_beat(OP_SET, CH_GREEN, MODE_SPARE5);
    send_beat(OP_SET, CH_WHITE, MODE_SPARE7);
    send_beat(OP_TICK, CH_BUZZER, MODE_LONG);
    send_beat(OP_SET, CH_BUZZER, MODE_SPARE6);
    send_beat(OP_SET, CH_BUZZER, MODE_LONG);
    send_beat(OP_TICK, CH_RED, MODE_SHORT);
    send_beat(OP_SET, CH_RED, MODE_OFF);
    drain_results();
  endtask

  // With sound disabled the buzzer pin keeps whatever level it had, even
  // while the buzzer status keeps toggling underneath.
  task automatic test_sound_freeze();
    write_registers(8'd255, 8'd1, 8'd1, 8'd0);
    send_beat(OP_SET, CH_BUZZER, MODE_MEANDER);
    send_beat(OP_TICK, CH_WHITE, MODE_SPARE6);
    send_beat(OP_TICK, CH_RED, MODE_ON);
    drain_results();
  endtask

  // Zero in a tick register loads a zero timer: timed lamps and a meander
  // buzzer freeze, and a short beep stays silent while keeping its mode.
  task automatic test_zero_timers();
    write_registers(8'd0, 8'd255, 8'd0, 8'd1);
    send_beat(OP_SET, CH_RED, MODE_SHORT);
    send_beat(OP_SET, CH_GREEN, MODE_MEANDER);
    send_beat(OP_SET, CH_WHITE, MODE_LONG);
    send_beat(OP_SET, CH_BUZZER, MODE_SHORT);
    send_beat(OP_TICK, CH_GREEN, MODE_SPARE5);
    send_beat(OP_SET, CH_BUZZER, MODE_MEANDER);
    send_beat(OP_TICK, CH_BUZZER, MODE_ON);
    drain_results();
  endtask

  // Mostly short tick counts so patterns wrap many times within a phase,
  // with the register extremes mixed in now and then.
  function automatic ticks_t draw_ticks();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd255;
      3, 4, 5: return ticks_t'($urandom_range(1, 6));
      default: return ticks_t'($urandom_range(1, 40));
    endcase
  endfunction

  // Random traffic in phases. Each phase drains the block, draws a fresh
  // configuration and idle behavior, then sends a mix dominated by ticks so
  // the patterns actually run, with set-mode commands on random channels.
  task automatic test_random_traffic();
    int sent;
    int phase_len;
    mode_t m;
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      drain_results();
      tx_no_idle = ($urandom_range(0, 3) == 0);
      rx_no_idle = ($urandom_range(0, 3) == 0);
      write_registers(draw_ticks(), draw_ticks(), draw_ticks(),
                      8'($urandom_range(0, 255)));
      phase_len = $urandom_range(50, 200);
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < 65) begin
          send_tick();
        end else begin
          if ($urandom_range(0, 99) < 85) m = mode_t'($urandom_range(0, 4));
          else m = mode_t'($urandom_range(5, 7));
          send_beat(OP_SET, chan_t'($urandom_range(0, 3)), m);
        end
        sent++;
      end
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    operation      = 1'b0;
    channel        = '0;
    mode_code      = '0;
    out_ready      = 1'b0;
    rx_stall       = 0;
    tx_no_idle     = 1'b0;
    rx_no_idle     = 1'b0;
    mismatch_count = 0;
    reset_patterns();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_mode_patterns();
    test_sound_freeze();
    test_zero_timers();
    test_random_traffic();

    // Everything is back; let the output register show any stray beat before
    // the verdict.
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("buzzer_lamp_pattern_sequencer regression: pass");
    end else begin
      $display("buzzer_lamp_pattern_sequencer regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("buzzer_lamp_pattern_sequencer regression: fail");
    $finish;
  end

endmodule

@@ buzzer_lamp_pattern_sequencer.f @@
rtl/blps_pkg.sv
rtl/buzzer_lamp_pattern_sequencer.sv
verif/tb.sv
